@@ sv/kgmq_pkg.sv @@
// ----------------------------------------------------------------------------
// kgmq_pkg: shared types and sizes for the keyframe-gated media queue
// Queue geometry, request codes and the stored descriptor layout.
// ----------------------------------------------------------------------------
package kgmq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int CHANNELS    = 8;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W = 56;
	localparam int HDL_W  = 16;
	localparam int CH_W   = 3;
	localparam int FILL_W = 7;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_TRIM  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef struct packed {
		logic              is_key;
		logic              is_video;
		logic [CH_W-1:0]   channel;
		logic [HDL_W-1:0]  handle;
		logic [TIME_W-1:0] ts;
	} entry_t;

endpackage

@@ sv/keyframe_gated_media_queue.sv @@
// ----------------------------------------------------------------------------
// keyframe_gated_media_queue: descriptor FIFO with keyframe gating and trim
// Push, pop, trim to last group of pictures, clear; one response per request.
// ----------------------------------------------------------------------------
// Steps: push, clear and any request on an empty queue go straight to the response;
// pop reads the head, then the new head when entries remain; trim makes a copy walk
// and, with a qualifying keyframe, then a compaction walk, one entry a cycle.
// Throughput: one request at a time; the next is taken the cycle after the
// response is loaded into the output register, which a stalled receiver holds.
// Reset: arst_n clears the queue, pointers and keyframe flags, not the stores.
module keyframe_gated_media_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] pkt_handle,
	input  logic [55:0] pkt_time,
	input  logic [2:0]  pkt_channel,
	input  logic        pkt_is_video,
	input  logic        pkt_is_key,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        pop_valid,
	output logic [15:0] pop_handle,
	output logic [55:0] pop_time,
	output logic [2:0]  pop_channel,
	output logic        pop_is_video,
	output logic        pop_is_key,
	output logic        push_stored,
	output logic        push_overflow,
	output logic [6:0]  fill_count,
	output logic [55:0] queue_span
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_HEAD,
		S_COPY,
		S_COMPACT,
		S_DONE
	} state_t;

	localparam int PTR_W  = kgmq_pkg::PTR_W;
	localparam int CNT_W  = kgmq_pkg::CNT_W;
	localparam int TIME_W = kgmq_pkg::TIME_W;
	localparam int NCH    = kgmq_pkg::CHANNELS;
	localparam int DEPTH  = kgmq_pkg::QUEUE_DEPTH;

	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH))
			sum = sum - (CNT_W+1)'(DEPTH);
		return sum[PTR_W-1:0];
	endfunction

	function automatic logic [NCH-1:0] ch_mask(input logic [2:0] ch);
		logic [NCH-1:0] m;
		for (int c = 0; c < NCH; c++)
			m[c] = (int'(ch) == c);
		return m;
	endfunction

	// storage
	kgmq_pkg::entry_t store_mem [DEPTH];
	kgmq_pkg::entry_t tmp_mem [DEPTH];
	kgmq_pkg::entry_t store_rd_q, tmp_rd_q;

	logic             store_we, tmp_we;
	logic [PTR_W-1:0] store_wa, store_ra, tmp_wa, tmp_ra;
	kgmq_pkg::entry_t store_wd, tmp_wd;

	// control and status
	state_t              state_q;
	logic [PTR_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [NCH-1:0]      key_seen_q, vid_seen_q;
	logic [TIME_W-1:0]   oldest_q, newest_q;
	logic [CNT_W-1:0]    step_q, m_q, key_idx_q;
	logic [2:0]          key_ch_q;
	logic                found_q;

	logic                res_pop_valid_q, res_stored_q, res_ovf_q;
	kgmq_pkg::entry_t    res_entry_q;

	logic                rsp_valid_q, pop_valid_q, push_stored_q, push_overflow_q;
	kgmq_pkg::entry_t    pop_entry_q;
	logic [6:0]          fill_count_q;
	logic [TIME_W-1:0]   queue_span_q;

	// combinational helpers
	kgmq_pkg::req_t      req;
	logic [NCH-1:0]      push_mask;
	logic                push_video, push_key, push_ch_ok, push_seen, push_ok, full;
	logic [PTR_W-1:0]    tail_slot, head_inc;
	logic [CNT_W-1:0]    j_idx;
	logic                copy_hit, keep_now, last_step;
	logic [TIME_W-1:0]   span_now;
	logic                rsp_load;

	assign req        = kgmq_pkg::req_t'(req_type);
	assign push_mask  = ch_mask(pkt_channel);
	assign push_video = pkt_is_video;
	assign push_key   = pkt_is_video & pkt_is_key;
	assign push_ch_ok = |push_mask;
	assign push_seen  = |(key_seen_q & push_mask);
	assign push_ok    = !push_video || (push_ch_ok && (push_key || push_seen));
	assign full       = (count_q >= CNT_W'(DEPTH));
	assign tail_slot  = slot_of(head_q, count_q);
	assign head_inc   = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign j_idx      = step_q - 1'b1;
	assign last_step  = (step_q == count_q);
	assign rsp_load   = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	// a keyframe with earlier video of its own channel ends the search
	assign copy_hit = (step_q != '0) && !found_q && store_rd_q.is_video &&
		store_rd_q.is_key && |(vid_seen_q & ch_mask(store_rd_q.channel));

	// keep everything from the keyframe on, and earlier video of other channels
	assign keep_now = (step_q != '0) && ((j_idx >= key_idx_q) ||
		(tmp_rd_q.is_video && tmp_rd_q.channel != key_ch_q));

	assign span_now = (count_q != '0 && newest_q > oldest_q) ? newest_q - oldest_q : '0;

	always_comb begin
		store_we = 1'b0;
		store_wa = tail_slot;
		store_wd = '{is_key: push_key, is_video: push_video, channel: pkt_channel,
			handle: pkt_handle, ts: pkt_time};
		store_ra = head_q;
		tmp_we   = 1'b0;
		tmp_wa   = j_idx[PTR_W-1:0];
		tmp_wd   = store_rd_q;
		tmp_ra   = step_q[PTR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				store_we = req_valid && req == kgmq_pkg::REQ_PUSH && push_ok && !full;
			end
			S_POP: begin
				store_ra = head_inc;
			end
			S_COPY: begin
				store_ra = slot_of(head_q, step_q);
				tmp_we   = (step_q != '0);
			end
			S_COMPACT: begin
				store_we = keep_now;
				store_wa = m_q[PTR_W-1:0];
				store_wd = tmp_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_we)
			store_mem[store_wa] <= store_wd;
		store_rd_q <= store_mem[store_ra];
	end

	always_ff @(posedge clk) begin
		if (tmp_we)
			tmp_mem[tmp_wa] <= tmp_wd;
		tmp_rd_q <= tmp_mem[tmp_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			head_q          <= '0;
			count_q         <= '0;
			key_seen_q      <= '0;
			vid_seen_q      <= '0;
			oldest_q        <= '0;
			newest_q        <= '0;
			step_q          <= '0;
			m_q             <= '0;
			key_idx_q       <= '0;
			key_ch_q        <= '0;
			found_q         <= 1'b0;
			res_pop_valid_q <= 1'b0;
			res_stored_q    <= 1'b0;
			res_ovf_q       <= 1'b0;
			res_entry_q     <= '0;
			rsp_valid_q     <= 1'b0;
			pop_valid_q     <= 1'b0;
			push_stored_q   <= 1'b0;
			push_overflow_q <= 1'b0;
			pop_entry_q     <= '0;
			fill_count_q    <= '0;
			queue_span_q    <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && !rsp_load)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						res_pop_valid_q <= 1'b0;
						res_stored_q    <= 1'b0;
						res_ovf_q       <= 1'b0;
						res_entry_q     <= '0;
						state_q         <= S_DONE;
						unique case (req)
							kgmq_pkg::REQ_PUSH: begin
								if (push_key && push_ch_ok)
									key_seen_q <= key_seen_q | push_mask;
								if (push_ok) begin
									if (full) begin
										res_ovf_q <= 1'b1;
									end else begin
										res_stored_q <= 1'b1;
										count_q      <= count_q + 1'b1;
										newest_q     <= pkt_time;
										if (count_q == '0)
											oldest_q <= pkt_time;
									end
								end
							end
							kgmq_pkg::REQ_POP: begin
								if (count_q != '0)
									state_q <= S_POP;
							end
							kgmq_pkg::REQ_TRIM: begin
								if (count_q == '0) begin
									head_q     <= '0;
									key_seen_q <= '0;
								end else begin
									step_q     <= '0;
									found_q    <= 1'b0;
									vid_seen_q <= '0;
									state_q    <= S_COPY;
								end
							end
							kgmq_pkg::REQ_CLEAR: begin
								head_q     <= '0;
								count_q    <= '0;
								key_seen_q <= '0;
							end
						endcase
					end
				end
				S_POP: begin
					res_pop_valid_q <= 1'b1;
					res_entry_q     <= store_rd_q;
					head_q          <= head_inc;
					count_q         <= count_q - 1'b1;
					// fetch the new head for the span
					state_q         <= (count_q == CNT_W'(1)) ? S_DONE : S_HEAD;
				end
				S_HEAD: begin
					oldest_q <= store_rd_q.ts;
					state_q  <= S_DONE;
				end
				S_COPY: begin
					if (copy_hit) begin
						found_q   <= 1'b1;
						key_idx_q <= j_idx;
						key_ch_q  <= store_rd_q.channel;
					end else if (step_q != '0 && !found_q && store_rd_q.is_video) begin
						vid_seen_q <= vid_seen_q | ch_mask(store_rd_q.channel);
					end
					if (last_step) begin
						if (found_q || copy_hit) begin
							step_q  <= '0;
							m_q     <= '0;
							state_q <= S_COMPACT;
						end else begin
							// no qualifying keyframe: drop everything
							head_q     <= '0;
							count_q    <= '0;
							key_seen_q <= '0;
							state_q    <= S_DONE;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_COMPACT: begin
					if (keep_now) begin
						m_q <= m_q + 1'b1;
						if (m_q == '0)
							oldest_q <= tmp_rd_q.ts;
					end
					if (last_step) begin
						head_q  <= '0;
						count_q <= m_q + CNT_W'(keep_now);
						state_q <= S_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_valid_q     <= 1'b1;
						pop_valid_q     <= res_pop_valid_q;
						pop_entry_q     <= res_entry_q;
						push_stored_q   <= res_stored_q;
						push_overflow_q <= res_ovf_q;
						fill_count_q    <= 7'(count_q);
						queue_span_q    <= span_now;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready     = (state_q == S_IDLE);
	assign rsp_valid     = rsp_valid_q;
	assign pop_valid     = pop_valid_q;
	assign pop_handle    = pop_entry_q.handle;
	assign pop_time      = pop_entry_q.ts;
	assign pop_channel   = pop_entry_q.channel;
	assign pop_is_video  = pop_entry_q.is_video;
	assign pop_is_key    = pop_entry_q.is_key;
	assign push_stored   = push_stored_q;
	assign push_overflow = push_overflow_q;
	assign fill_count    = fill_count_q;
	assign queue_span    = queue_span_q;

endmodule

@@ verif/tb_keyframe_gated_media_queue.sv @@
// ----------------------------------------------------------------------------
// tb_keyframe_gated_media_queue: self-checking bench for the media queue
// Drives push, pop, trim and clear requests through the request channel and
// checks every response beat against an in-bench model of the descriptor
// queue: keyframe gating per channel, overflow, trim to the last group of
// pictures, fill count and time span. Both channels idle at random, and the
// response side holds off for long stretches so that the request side stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyframe_gated_media_queue;

	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int RANDOM_ITEMS = 1500;

	typedef struct {
		kgmq_pkg::req_t                      kind;
		logic [kgmq_pkg::HDL_W-1:0]  handle;
		logic [kgmq_pkg::TIME_W-1:0] ts;
		logic [kgmq_pkg::CH_W-1:0]   chan;
		logic                        video;
		logic                        key;
	} media_req_t;

	typedef struct {
		logic                        pop_valid;
		logic [kgmq_pkg::HDL_W-1:0]  handle;
		logic [kgmq_pkg::TIME_W-1:0] ts;
		logic [kgmq_pkg::CH_W-1:0]   chan;
		logic                        video;
		logic                        key;
		logic                        stored;
		logic                        overflow;
		logic [kgmq_pkg::FILL_W-1:0] fill;
		logic [kgmq_pkg::TIME_W-1:0] span;
	} media_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [1:0]  req_type = kgmq_pkg::REQ_PUSH;
	logic [15:0] pkt_handle = '0;
	logic [55:0] pkt_time = '0;
	logic [2:0]  pkt_channel = '0;
	logic        pkt_is_video = 1'b0;
	logic        pkt_is_key = 1'b0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic        pop_valid;
	logic [15:0] pop_handle;
	logic [55:0] pop_time;
	logic [2:0]  pop_channel;
	logic        pop_is_video;
	logic        pop_is_key;
	logic        push_stored;
	logic        push_overflow;
	logic [6:0]  fill_count;
	logic [55:0] queue_span;

	keyframe_gated_media_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.pkt_handle   (pkt_handle),
		.pkt_time     (pkt_time),
		.pkt_channel  (pkt_channel),
		.pkt_is_video (pkt_is_video),
		.pkt_is_key   (pkt_is_key),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.pop_valid    (pop_valid),
		.pop_handle   (pop_handle),
		.pop_time     (pop_time),
		.pop_channel  (pop_channel),
		.pop_is_video (pop_is_video),
		.pop_is_key   (pop_is_key),
		.push_stored  (push_stored),
		.push_overflow(push_overflow),
		.fill_count   (fill_count),
		.queue_span   (queue_span)
	);

	always #2 clk = ~clk;

	// Model of the descriptor queue
	logic [kgmq_pkg::TIME_W-1:0] held_ts[kgmq_pkg::QUEUE_DEPTH];
	logic [kgmq_pkg::HDL_W-1:0]  held_handle[kgmq_pkg::QUEUE_DEPTH];
	logic [kgmq_pkg::CH_W-1:0]   held_chan[kgmq_pkg::QUEUE_DEPTH];
	logic                        held_video[kgmq_pkg::QUEUE_DEPTH];
	logic                        held_key[kgmq_pkg::QUEUE_DEPTH];
	int                          held_head = 0;
	int                          held_count = 0;
	bit [kgmq_pkg::CHANNELS-1:0] key_seen_ch = '0;

	media_req_t request_backlog[$];
	media_rsp_t expected_replies[$];

	bit req_beat = 1'b0;
	bit rsp_beat = 1'b0;
	int mismatches = 0;
	int cycles = 0;

	int req_gap = 0, req_left = 0, rsp_stall = 0, rsp_left = 0;
	bit req_calm = 1'b0, rsp_calm = 1'b0;
	int hold_left = 0;
	int replies_taken = 0;

	logic [kgmq_pkg::TIME_W-1:0] ts_run = '0;

	function automatic void drop_all_packets();
		held_head = 0;
		held_count = 0;
		key_seen_ch = '0;
	endfunction

	function automatic media_rsp_t apply_media_request(media_req_t rq);
		media_rsp_t r;
		bit accept, key;
		int slot, n, hit, m;
		logic [kgmq_pkg::TIME_W-1:0] t_ts[kgmq_pkg::QUEUE_DEPTH];
		logic [kgmq_pkg::HDL_W-1:0]  t_handle[kgmq_pkg::QUEUE_DEPTH];
		logic [kgmq_pkg::CH_W-1:0]   t_chan[kgmq_pkg::QUEUE_DEPTH];
		logic                        t_video[kgmq_pkg::QUEUE_DEPTH];
		logic                        t_key[kgmq_pkg::QUEUE_DEPTH];
		logic [kgmq_pkg::TIME_W-1:0] oldest, newest;
		r = '{default: '0};
		case (rq.kind)
			kgmq_pkg::REQ_PUSH: begin
				// key flag counts only on video
				key = rq.video && rq.key;
				accept = 1'b1;
				if (rq.video) begin
					if (rq.chan >= kgmq_pkg::CHANNELS) begin
						accept = 1'b0;
					end else begin
						if (key)
							key_seen_ch[rq.chan] = 1'b1;
						if (!key_seen_ch[rq.chan] && !key)
							accept = 1'b0;
					end
				end
				if (accept) begin
					if (held_count >= kgmq_pkg::QUEUE_DEPTH) begin
						r.overflow = 1'b1;
					end else begin
						slot = (held_head + held_count) % kgmq_pkg::QUEUE_DEPTH;
						held_ts[slot] = rq.ts;
						held_handle[slot] = rq.handle;
						held_chan[slot] = rq.chan;
						held_video[slot] = rq.video;
						held_key[slot] = key;
						held_count++;
						r.stored = 1'b1;
					end
				end
			end
			kgmq_pkg::REQ_POP: begin
				if (held_count > 0) begin
					r.pop_valid = 1'b1;
					r.handle = held_handle[held_head];
					r.ts = held_ts[held_head];
					r.chan = held_chan[held_head];
					r.video = held_video[held_head];
					r.key = held_key[held_head];
					held_head = (held_head + 1) % kgmq_pkg::QUEUE_DEPTH;
					held_count--;
				end
			end
			kgmq_pkg::REQ_TRIM: begin
				n = held_count;
				for (int i = 0; i < n; i++) begin
					slot = (held_head + i) % kgmq_pkg::QUEUE_DEPTH;
					t_ts[i] = held_ts[slot];
					t_handle[i] = held_handle[slot];
					t_chan[i] = held_chan[slot];
					t_video[i] = held_video[slot];
					t_key[i] = held_key[slot];
				end
				// first keyframe with older video of its own channel
				hit = -1;
				for (int k = 0; k < n && hit < 0; k++) begin
					if (t_video[k] && t_key[k]) begin
						for (int j = 0; j < k; j++)
							if (t_video[j] && t_chan[j] == t_chan[k])
								hit = k;
					end
				end
				if (hit < 0) begin
					drop_all_packets();
				end else begin
					m = 0;
					for (int j = 0; j < n; j++) begin
						if (j >= hit || (t_video[j] && t_chan[j] != t_chan[hit])) begin
							held_ts[m] = t_ts[j];
							held_handle[m] = t_handle[j];
							held_chan[m] = t_chan[j];
							held_video[m] = t_video[j];
							held_key[m] = t_key[j];
							m++;
						end
					end
					held_head = 0;
					held_count = m;
				end
			end
			default: drop_all_packets();
		endcase
		if (held_count > 0) begin
			oldest = held_ts[held_head];
			newest = held_ts[(held_head + held_count - 1) % kgmq_pkg::QUEUE_DEPTH];
			if (newest > oldest)
				r.span = newest - oldest;
		end
		r.fill = held_count[kgmq_pkg::FILL_W-1:0];
		return r;
	endfunction

	function automatic void add_request(kgmq_pkg::req_t kind,
			logic [kgmq_pkg::HDL_W-1:0] h, logic [kgmq_pkg::TIME_W-1:0] ts,
			logic [kgmq_pkg::CH_W-1:0] ch, logic v, logic k);
		media_req_t rq;
		rq.kind = kind;
		rq.handle = h;
		rq.ts = ts;
		rq.chan = ch;
		rq.video = v;
		rq.key = k;
		request_backlog = {request_backlog, rq};
	endfunction

	function automatic logic [kgmq_pkg::TIME_W-1:0] rand56();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[kgmq_pkg::TIME_W-1:0];
	endfunction

	// Wait before the next beat; switch between calm and busy stretches now and then
	function automatic int draw_wait(ref int left, ref bit calm);
		if (left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			left = $urandom_range(20, 60);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Request driver: hold the beat until taken, then idle for the drawn gap
	always @(negedge clk) begin : drive_requests
		media_req_t nxt;
		if (arst_n && !(req_valid && !req_beat)) begin
			if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (request_backlog.size() != 0) begin
				nxt = request_backlog[0];
				request_backlog.delete(0);
				req_type <= nxt.kind;
				pkt_handle <= nxt.handle;
				pkt_time <= nxt.ts;
				pkt_channel <= nxt.chan;
				pkt_is_video <= nxt.video;
				pkt_is_key <= nxt.key;
				req_valid <= 1'b1;
				req_gap = draw_wait(req_left, req_calm);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response side: per-beat stall, plus a long hold-off every 500 beats
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_beat) begin
				replies_taken++;
				if (replies_taken % 500 == 300)
					hold_left = 400;
				rsp_stall = draw_wait(rsp_left, rsp_calm);
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (rsp_stall > 0) begin
				rsp_stall--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on each request beat, check each response beat
	always @(posedge clk) begin : watch_beats
		media_req_t acc;
		media_rsp_t want;
		media_rsp_t pred;
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d responses outstanding", $time, expected_replies.size());
			$display("Verification failed");
			$finish;
		end
		req_beat = arst_n && req_valid && req_ready;
		rsp_beat = arst_n && rsp_valid && rsp_ready;
		if (rsp_beat) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected response: expected none, got fill_count %0d",
					$time, fill_count);
				mismatches++;
			end else begin
				want = expected_replies[0];
				expected_replies.delete(0);
				check_field("pop_valid", 64'(want.pop_valid), 64'(pop_valid));
				check_field("pop_handle", 64'(want.handle), 64'(pop_handle));
				check_field("pop_time", 64'(want.ts), 64'(pop_time));
				check_field("pop_channel", 64'(want.chan), 64'(pop_channel));
				check_field("pop_is_video", 64'(want.video), 64'(pop_is_video));
				check_field("pop_is_key", 64'(want.key), 64'(pop_is_key));
				check_field("push_stored", 64'(want.stored), 64'(push_stored));
				check_field("push_overflow", 64'(want.overflow), 64'(push_overflow));
				check_field("fill_count", 64'(want.fill), 64'(fill_count));
				check_field("queue_span", 64'(want.span), 64'(queue_span));
			end
		end
		if (req_beat) begin
			acc.kind = kgmq_pkg::req_t'(req_type);
			acc.handle = pkt_handle;
			acc.ts = pkt_time;
			acc.chan = pkt_channel;
			acc.video = pkt_is_video;
			acc.key = pkt_is_key;
			pred = apply_media_request(acc);
			expected_replies = {expected_replies, pred};
		end
	end

	initial begin : stimulus
		int n_random, phase_len, mode, roll;
		int push_cut, pop_cut, trim_cut;
		logic [kgmq_pkg::CH_W-1:0] ch;
		logic [kgmq_pkg::TIME_W-1:0] ts;

		// directed: empty queue, gating, key flag on non-video, trim both ways, clear
		add_request(kgmq_pkg::REQ_POP, 16'h0, '0, 3'd0, 1'b0, 1'b0);
		add_request(kgmq_pkg::REQ_TRIM, 16'h0, '0, 3'd0, 1'b0, 1'b0);
		add_request(kgmq_pkg::REQ_PUSH, 16'h0011, 56'd10, 3'd0, 1'b1, 1'b0);
		add_request(kgmq_pkg::REQ_PUSH, 16'hFFFF, '1, 3'd5, 1'b0, 1'b1);
		add_request(kgmq_pkg::REQ_PUSH, 16'h0000, '0, 3'd7, 1'b1, 1'b1);
		add_request(kgmq_pkg::REQ_POP, 16'h0, '0, 3'd0, 1'b0, 1'b0);
		add_request(kgmq_pkg::REQ_PUSH, 16'h1234, 56'd100, 3'd7, 1'b1, 1'b0);
		add_request(kgmq_pkg::REQ_PUSH, 16'h2222, 56'd150, 3'd1, 1'b0, 1'b0);
		add_request(kgmq_pkg::REQ_PUSH, 16'h3333, 56'd200, 3'd7, 1'b1, 1'b1);
		add_request(kgmq_pkg::REQ_PUSH, 16'h4444, 56'd250, 3'd2, 1'b1, 1'b1);
		add_request(kgmq_pkg::REQ_TRIM, 16'h0, '0, 3'd0, 1'b0, 1'b0);
		add_request(kgmq_pkg::REQ_POP, 16'h0, '0, 3'd0, 1'b0, 1'b0);
		add_request(kgmq_pkg::REQ_TRIM, 16'h0, '0, 3'd0, 1'b0, 1'b0);
		add_request(kgmq_pkg::REQ_PUSH, 16'h5555, 56'd300, 3'd7, 1'b1, 1'b0);
		add_request(kgmq_pkg::REQ_PUSH, 16'hAAAA, '1, 3'd3, 1'b1, 1'b1);
		add_request(kgmq_pkg::REQ_PUSH, 16'h5A5A, 56'd5, 3'd3, 1'b1, 1'b0);
		add_request(kgmq_pkg::REQ_CLEAR, 16'hFFFF, '1, 3'd7, 1'b1, 1'b1);
		add_request(kgmq_pkg::REQ_PUSH, 16'h0F0F, 56'd400, 3'd3, 1'b1, 1'b0);
		add_request(kgmq_pkg::REQ_POP, 16'hFFFF, '1, 3'd7, 1'b1, 1'b1);

		// random phases: fill-heavy first so the queue reaches full and overflows
		n_random = 0;
		mode = 0;
		phase_len = 150;
		while (n_random < RANDOM_ITEMS) begin
			case (mode)
				0: begin push_cut = 88; pop_cut = 96; trim_cut = 99; end
				1: begin push_cut = 30; pop_cut = 92; trim_cut = 98; end
				default: begin push_cut = 55; pop_cut = 90; trim_cut = 98; end
			endcase
			for (int i = 0; i < phase_len; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < push_cut) begin
					ch = $urandom_range(0, 1) ? 3'($urandom_range(0, 2)) :
						3'($urandom_range(0, 7));
					roll = $urandom_range(0, 99);
					if (roll < 80) begin
						ts_run = ts_run + 56'($urandom_range(0, 5000));
						ts = ts_run;
					end else if (roll < 90) begin
						ts = rand56();
					end else if (roll < 95) begin
						ts = '1;
					end else begin
						ts = ts_run - 56'($urandom_range(0, 20000));
					end
					add_request(kgmq_pkg::REQ_PUSH, 16'($urandom_range(0, 65535)), ts, ch,
						$urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
				end else begin
					add_request(roll < pop_cut ? kgmq_pkg::REQ_POP :
						(roll < trim_cut ? kgmq_pkg::REQ_TRIM : kgmq_pkg::REQ_CLEAR),
						16'($urandom_range(0, 65535)), rand56(), 3'($urandom_range(0, 7)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end
			n_random += phase_len;
			mode = $urandom_range(0, 2);
			phase_len = $urandom_range(40, 120);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
		// allow a full trim walk for anything still in flight
		repeat (2 * kgmq_pkg::QUEUE_DEPTH + 16) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
